/* hdl/sm3_stream_hash_macros.svh */
// Assertion macros shared by the SM3 hash checker.
`ifndef SM3_STREAM_HASH_MACROS_SVH
`define SM3_STREAM_HASH_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SM3_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/sm3_pkg.sv */
// Package with SM3 constants, types and round functions.
`default_nettype none
package sm3_pkg;
    localparam int LenBits = 61;
    localparam logic [31:0] TLow  = 32'h79CC4519;
    localparam logic [31:0] THigh = 32'h7A879D8A;
    localparam logic [7:0]  PadMark = 8'h80;
    localparam logic [255:0] Iv = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                   32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    // Commands from controller to datapath.
    typedef struct packed {
        logic       wr_byte;   // write a byte into buffer at fill position
        logic [7:0] wr_data;
        logic       wr_len;    // write length field into last eight bytes
        logic       clr_cnt;   // clear fill count
        logic       inc_len;   // count one message byte
        logic       start;     // begin compression
        logic       rst_cv;    // restore chaining value and length
        logic       shift_out; // rotate digest word out
    } t_cmd;

    typedef struct packed {
        logic [6:0] fill;
        logic       busy;
    } t_sts;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage
`default_nettype wire

/* hdl/sm3_stream_hash.sv */
// Top level of the SM3 stream hash.
// Usage:
//   Slave channel: one message byte per beat. s_axis_tdata carries the byte,
//   s_axis_tuser flags that the byte belongs to the message (clear only on an
//   empty final beat), s_axis_tlast marks the last beat of a message.
//   Master channel: eight beats per message, the digest words in order,
//   m_axis_tuser carrying the word index, m_axis_tlast on word seven.
// Flow:
//   A byte that does not complete a block is written; unless it ends the
//   message, input stays ready. The 64th byte of a block starts the round unit,
//   one round a cycle, and no beat is taken until the compression is done. The
//   last beat adds zero-fill writes (the buffer takes one byte a cycle) and one
//   or two compressions, then eight digest beats, one a cycle when unstalled.
// Reset: synchronous, active low; restores the IV, clears the counts.
// Stall: while the receiver holds m_axis_tready low the word waits and no new
//   input beat is taken until the last digest word has gone.
`default_nettype none
module sm3_stream_hash import sm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_data
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);
    t_cmd cmd;
    t_sts sts;

    // sequence input, padding and output
    sm3_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_byte(s_axis_tdata), .i_has(s_axis_tuser),
        .i_eom(s_axis_tlast), .o_ready(s_axis_tready),
        .i_sts(sts), .o_cmd(cmd),
        .o_valid(m_axis_tvalid), .o_idx(m_axis_tuser), .i_out_ready(m_axis_tready)
    );

    // buffer, schedule and rounds
    sm3_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts), .o_word(m_axis_tdata)
    );

    assign m_axis_tlast = (m_axis_tuser == 3'd7);
endmodule
`default_nettype wire

/* hdl/sm3_dp.sv */
// SM3 datapath: block buffer, message schedule, round unit, chaining value.
`default_nettype none
module sm3_dp import sm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    output logic [31:0]      o_word
);
    logic [511:0]      r_blk, n_blk;
    logic [6:0]        r_fill, n_fill;
    logic [LenBits-1:0] r_len, n_len;
    logic [255:0]      r_cv, n_cv;
    logic [255:0]      r_st, n_st;
    logic [31:0]       r_w [16];
    logic [6:0]        r_rnd, n_rnd;
    logic              r_busy, n_busy;
    logic [63:0]       bits;
    logic [31:0]       a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [31:0]       wnew, wj, wpj;
    logic              lo;

    assign bits = 64'({r_len, 3'b000});
    assign o_sts = '{fill: r_fill, busy: r_busy};
    assign o_word = r_cv[255:224];

    // Block bytes shift in at the low end; the first byte ends up at the top.
    always_comb begin
        n_blk = r_blk;
        if (i_cmd.wr_byte) n_blk = {r_blk[503:0], i_cmd.wr_data};
        else if (i_cmd.wr_len) n_blk = {r_blk[447:0], bits};
    end

    // Schedule window: w[j..j+15]; next word from taps.
    assign wnew = p1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15)) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    assign wj   = r_w[0];
    assign wpj  = r_w[0] ^ r_w[4];
    assign lo   = (r_rnd < 7'd16);
    assign {a, b, c, d, e, f, g, h} = r_st;
    assign tj   = rotl(lo ? TLow : THigh, r_rnd[4:0]);
    assign a12  = rotl(a, 5'd12);
    assign ss1  = rotl(a12 + e + tj, 5'd7);
    assign ss2  = ss1 ^ a12;
    assign ff   = lo ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
    assign gg   = lo ? (e ^ f ^ g) : ((e & f) | (~e & g));
    assign tt1  = ff + d + ss2 + wpj;
    assign tt2  = gg + h + ss1 + wj;

    always_comb begin
        n_fill = r_fill;
        n_len  = r_len;
        n_cv   = r_cv;
        n_st   = r_st;
        n_rnd  = r_rnd;
        n_busy = r_busy;
        if (i_cmd.wr_byte) n_fill = r_fill + 7'd1;
        if (i_cmd.inc_len) n_len = r_len + 1'b1;
        if (i_cmd.clr_cnt) n_fill = '0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_rnd  = '0;
            n_st   = r_cv;
        end else if (r_busy) begin
            n_st = {tt1, a, rotl(b, 5'd9), c, p0(tt2), e, rotl(f, 5'd19), g};
            n_rnd = r_rnd + 7'd1;
            if (r_rnd == 7'd63) begin
                n_busy = 1'b0;
                n_cv = r_cv ^ n_st;
            end
        end
        if (i_cmd.shift_out) n_cv = {r_cv[223:0], r_cv[255:224]};
        if (i_cmd.rst_cv) begin
            n_cv  = Iv;
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= '0;
            r_cv   <= Iv;
            r_busy <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_fill <= n_fill;
            r_len  <= n_len;
            r_cv   <= n_cv;
            r_busy <= n_busy;
            r_rnd  <= n_rnd;
        end
        r_blk <= n_blk;
        r_st  <= n_st;
        // load from the next block value so a byte written with start is included
        if (i_cmd.start) begin
            for (int k = 0; k < 16; k++)
                r_w[k] <= n_blk[511-32*k -: 32];
        end else if (r_busy) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= wnew;
        end
    end
endmodule
`default_nettype wire

/* hdl/sm3_ctrl.sv */
// SM3 controller: input handshake, padding sequence and digest output.
`default_nettype none
module sm3_ctrl import sm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_has,
    input  wire logic        i_eom,
    output logic             o_ready,
    input  wire t_sts        i_sts,
    output t_cmd             o_cmd,
    output logic             o_valid,
    output logic [2:0]       o_idx,
    input  wire logic        i_out_ready
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_DATA = 7'b0000010, S_PAD = 7'b0000100,
        S_ZERO = 7'b0001000, S_LAST = 7'b0010000, S_FIN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_eom, n_eom;
    logic [2:0] r_idx, n_idx;
    logic       acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;
    assign o_valid = (r_state == S_OUT);
    assign o_idx   = r_idx;

    always_comb begin
        n_state = r_state;
        n_eom   = r_eom;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_eom = i_eom;
                    if (i_has) begin
                        o_cmd.wr_byte = 1'b1;
                        o_cmd.wr_data = i_byte;
                        o_cmd.inc_len = 1'b1;
                        if (i_sts.fill == 7'd63) begin
                            o_cmd.start = 1'b1;
                            n_state = S_DATA;
                        end else if (i_eom) n_state = S_PAD;
                    end else if (i_eom) n_state = S_PAD;
                end
            end
            S_DATA: begin
                // compression of a full block; the write moved fill to 64
                if (!i_sts.busy) begin
                    o_cmd.clr_cnt = 1'b1;
                    n_state = r_eom ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.wr_byte = 1'b1;
                o_cmd.wr_data = PadMark;
                n_state = S_ZERO;
            end
            S_ZERO: begin
                if (i_sts.fill == 7'd64) begin
                    o_cmd.start = 1'b1;
                    n_state = S_FIN;
                    n_eom = 1'b0;
                end else if (i_sts.fill == 7'd56 && r_eom) begin
                    o_cmd.wr_len = 1'b1;
                    o_cmd.start  = 1'b1;
                    n_state = S_LAST;
                end else begin
                    o_cmd.wr_byte = 1'b1;
                    o_cmd.wr_data = 8'h00;
                end
            end
            S_FIN: begin
                // extra padding block; then a zero block carrying the length
                if (!i_sts.busy && !o_cmd.start) begin
                    o_cmd.clr_cnt = 1'b1;
                    n_eom = 1'b1;
                    n_state = S_ZERO;
                end
            end
            S_LAST: begin
                if (!i_sts.busy) begin
                    n_idx = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.shift_out = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.rst_cv  = 1'b1;
                        o_cmd.clr_cnt = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eom   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_eom   <= n_eom;
            r_idx   <= n_idx;
        end
    end
endmodule
`default_nettype wire

/* hdl/sm3_stream_hash_chk.sv */
// Port checker for the SM3 stream hash, bound to the top level.
`default_nettype none
`include "sm3_stream_hash_macros.svh"
module sm3_stream_hash_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    `SM3_ASSERT_IMPL(a_no_in_during_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SM3_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 3'd7))
    `SM3_ASSERT_NEXT(a_idx_adv, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
    `SM3_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind sm3_stream_hash sm3_stream_hash_chk u_chk (.*);
`default_nettype wire
